FILE: rtl/tkri_pkg.sv
// shared types and constants for the ranked top-k insertion block
package tkri_pkg;

  localparam int KIND_W    = 2;
  localparam int SEL_W     = 2;
  localparam int ID_W      = 32;
  localparam int SCORE_W   = 31;
  localparam int RSLOT_W   = 4;
  localparam int PSLOT_W   = 4;
  localparam int NUM_LISTS = 3;
  localparam int IN_W      = 72;
  localparam int OUT_W     = 72;

  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

  localparam logic [SEL_W-1:0] SEL_NONE = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [SCORE_W-1:0] score;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_RDWAIT = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

endpackage

FILE: rtl/tkri_ram.sv
// generic single-write, single-read ram with registered read data
module tkri_ram #(
  parameter int WIDTH = 63,
  parameter int DEPTH = 30,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/top_k_ranked_insert.sv
// top level of the ranked top-k insertion lists
// throughput: one transaction at a time, the next one accepted only once the last
//   result has moved into the output register; an insert walks every slot
//   of its list once through the single comparator, writing slots from its placement on
// reset: rst (synchronous) clears all per-entry valid bits, so every list reads as zero;
//   a clear transaction does the same as it is accepted, no ram sweep is needed
// the output register holds a finished result while the next transaction is accepted
module top_k_ranked_insert #(
  parameter int LIST_DEPTH = 10
) (
  input  logic                      clk,
  input  logic                      rst,
  // input stream
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // list_select[1:0], record_id[33:2], score[64:34], read_slot[68:65], zero fill
  input  logic [tkri_pkg::IN_W-1:0] s_tdata,
  // kind[1:0]
  input  logic [tkri_pkg::KIND_W-1:0] s_tuser,
  // output stream
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // placed[0], placed_slot[4:1], entry_id[36:5], entry_score[67:37], zero fill
  output logic [tkri_pkg::OUT_W-1:0] m_tdata
);

  localparam int SLOT_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int NUM_ENT = tkri_pkg::NUM_LISTS * LIST_DEPTH;
  localparam int ADDR_W  = $clog2(NUM_ENT);
  localparam int ENT_W   = $bits(tkri_pkg::entry_t);

  // unpacked input fields
  logic [tkri_pkg::SEL_W-1:0]   in_sel;
  logic [tkri_pkg::ID_W-1:0]    in_id;
  logic [tkri_pkg::SCORE_W-1:0] in_score;
  logic [tkri_pkg::RSLOT_W-1:0] in_rslot;

  assign in_sel   = s_tdata[1:0];
  assign in_id    = s_tdata[33:2];
  assign in_score = s_tdata[64:34];
  assign in_rslot = s_tdata[68:65];

  // sequencer state
  tkri_pkg::state_t state;
  logic [SLOT_W-1:0] kcnt;       // slot under compare during a scan
  logic [ADDR_W-1:0] addr;       // ram address of that slot
  logic              inserted;   // new record already written this scan
  tkri_pkg::entry_t  new_entry;
  tkri_pkg::entry_t  carry;      // displaced entry shifting down
  logic [NUM_ENT-1:0] valid;     // entry written since last clear
  logic              rd_valid;

  // result holding
  logic              res_placed;
  logic [SLOT_W-1:0] res_slot;
  tkri_pkg::entry_t  res_entry;
  logic [SLOT_W+3:0] slot_ext;

  // ram ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ENT_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [ENT_W-1:0]  ram_rdata;

  logic              in_fire;
  logic              ins_ok;
  logic              rd_ok;
  logic [ADDR_W-1:0] base;
  tkri_pkg::entry_t  cur;
  logic              beats;
  logic              last_slot;
  logic              out_load;

  assign s_tready = !rst && (state == tkri_pkg::ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;

  assign ins_ok = (in_score != '0) && (in_sel != tkri_pkg::SEL_NONE);
  assign rd_ok  = (in_sel != tkri_pkg::SEL_NONE) &&
                  ({3'b000, in_rslot} < 7'(LIST_DEPTH));
  assign base   = ADDR_W'(in_sel) * ADDR_W'(LIST_DEPTH);

  // never-written entries read as zero
  assign cur       = rd_valid ? tkri_pkg::entry_t'(ram_rdata) : '0;
  // the shared comparator: new score strictly above the stored one
  assign beats     = new_entry.score > cur.score;
  assign last_slot = (kcnt == SLOT_W'(LIST_DEPTH - 1));

  // result moves into the output register once that register is free
  assign out_load = (state == tkri_pkg::ST_FINISH) && (!m_tvalid || m_tready);

  // ram control: read slot k+1 while slot k is compared and, from the placement on, rewritten
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = addr;
    ram_we    = 1'b0;
    ram_waddr = addr;
    ram_wdata = inserted ? carry : new_entry;
    case (state)
      tkri_pkg::ST_IDLE: begin
        if (in_fire && (s_tuser == tkri_pkg::KIND_INSERT) && ins_ok) begin
          ram_re    = 1'b1;
          ram_raddr = base;
        end else if (in_fire && (s_tuser == tkri_pkg::KIND_READ) && rd_ok) begin
          ram_re    = 1'b1;
          ram_raddr = base + ADDR_W'(in_rslot);
        end
      end
      tkri_pkg::ST_SCAN: begin
        ram_we = inserted || beats;
        if (!last_slot) begin
          ram_re    = 1'b1;
          ram_raddr = addr + ADDR_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  tkri_ram #(
    .WIDTH(ENT_W),
    .DEPTH(NUM_ENT)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // placed_slot is the slot masked to its field width
  assign slot_ext = {4'b0000, res_slot};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= tkri_pkg::ST_IDLE;
      valid    <= '0;
      rd_valid <= 1'b0;
      inserted <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (ram_re) begin
        rd_valid <= valid[ram_raddr];
      end
      if (ram_we) begin
        valid[ram_waddr] <= 1'b1;
      end
      case (state)
        tkri_pkg::ST_IDLE: begin
          if (in_fire) begin
            new_entry.id    <= in_id;
            new_entry.score <= in_score;
            res_placed      <= 1'b0;
            res_slot        <= '0;
            res_entry       <= '0;
            inserted        <= 1'b0;
            kcnt            <= '0;
            addr            <= base;
            case (s_tuser)
              tkri_pkg::KIND_CLEAR: begin
                valid <= '0;
                state <= tkri_pkg::ST_FINISH;
              end
              tkri_pkg::KIND_INSERT: begin
                state <= ins_ok ? tkri_pkg::ST_SCAN : tkri_pkg::ST_FINISH;
              end
              tkri_pkg::KIND_READ: begin
                state <= rd_ok ? tkri_pkg::ST_RDWAIT : tkri_pkg::ST_FINISH;
              end
              default: begin
                state <= tkri_pkg::ST_FINISH;
              end
            endcase
          end
        end
        tkri_pkg::ST_RDWAIT: begin
          res_entry <= cur;
          state     <= tkri_pkg::ST_FINISH;
        end
        tkri_pkg::ST_SCAN: begin
          // the entry just read moves one place down on the next write
          carry <= cur;
          if (!inserted && beats) begin
            inserted   <= 1'b1;
            res_placed <= 1'b1;
            res_slot   <= kcnt;
          end
          if (last_slot) begin
            state <= tkri_pkg::ST_FINISH;
          end else begin
            kcnt <= kcnt + SLOT_W'(1);
            addr <= addr + ADDR_W'(1);
          end
        end
        tkri_pkg::ST_FINISH: begin
          if (out_load) begin
            m_tdata  <= {4'b0000, res_entry.score, res_entry.id,
                         slot_ext[3:0], res_placed};
            state    <= tkri_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= tkri_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // a clear transaction empties every list by the next cycle
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (in_fire && (s_tuser == tkri_pkg::KIND_CLEAR)) |=> (valid == '0))
    else $error("lists not empty after clear");

  // a placed record always lands inside its list
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    ((state == tkri_pkg::ST_FINISH) && res_placed) |->
      (res_slot <= SLOT_W'(LIST_DEPTH - 1)))
    else $error("placed slot beyond list depth");

  // list storage changes only during an insert scan
  a_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == tkri_pkg::ST_SCAN))
    else $error("ram write outside insert scan");

  // once placed, every later slot of the scan is rewritten with the shifted entry
  a_shift_writes: assert property (@(posedge clk) disable iff (rst)
    ((state == tkri_pkg::ST_SCAN) && inserted) |-> ram_we)
    else $error("shift-down write missing after placement");

endmodule

FILE: tb/testbench.sv
// self-checking testbench for the ranked top-k insertion lists
`timescale 1ns / 100ps

module testbench;

  localparam int DEPTH          = 10;
  localparam int ITEMS_PER_PASS = 410;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int NUM_DIRECTED   = 22;

  // kind code the block leaves unused
  localparam logic [tkri_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [tkri_pkg::KIND_W-1:0]  kind;
    logic [tkri_pkg::SEL_W-1:0]   sel;
    logic [tkri_pkg::ID_W-1:0]    id;
    logic [tkri_pkg::SCORE_W-1:0] score;
    logic [tkri_pkg::RSLOT_W-1:0] slot;
  } item_t;

  typedef struct packed {
    logic                         placed;
    logic [tkri_pkg::PSLOT_W-1:0] pslot;
    logic [tkri_pkg::ID_W-1:0]    eid;
    logic [tkri_pkg::SCORE_W-1:0] escore;
  } result_t;

  // one directed row: the transaction and, where obvious, its typed-in answer
  typedef struct packed {
    item_t   it;
    bit      fixed;
    result_t want;
  } row_t;

  localparam result_t ALL_ZERO = '0;
  localparam result_t PLACED_TOP = '{1'b1, 4'd0, 32'd0, 31'd0};

  logic                          clk      = 1'b0;
  logic                          rst      = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [tkri_pkg::IN_W-1:0]     s_tdata  = '0;
  logic [tkri_pkg::KIND_W-1:0]   s_tuser  = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [tkri_pkg::OUT_W-1:0]    m_tdata;

  // typed-in answer travels with the transaction, beside the bus rather than on it
  bit                  fixed_answer_on = 1'b0;
  result_t             fixed_answer    = '0;

  // local copy of the three ranked lists
  logic [tkri_pkg::ID_W-1:0]    list_ids    [tkri_pkg::NUM_LISTS][DEPTH];
  logic [tkri_pkg::SCORE_W-1:0] list_scores [tkri_pkg::NUM_LISTS][DEPTH];

  result_t             pending_results [$];
  row_t                directed_rows [NUM_DIRECTED];
  bit                  mismatch_seen = 1'b0;
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  int                  cycle_count   = 0;

  top_k_ranked_insert #(.LIST_DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #1 clk = ~clk;

  // updates the local lists and returns the result the block should give
  function automatic result_t apply_to_lists(input item_t it);
    result_t r;
    int      pos;
    r = '0;
    case (it.kind)
      tkri_pkg::KIND_CLEAR: begin
        for (int l = 0; l < tkri_pkg::NUM_LISTS; l++) begin
          for (int e = 0; e < DEPTH; e++) begin
            list_ids[l][e]    = '0;
            list_scores[l][e] = '0;
          end
        end
      end
      tkri_pkg::KIND_INSERT: begin
        if (it.score != 0 && it.sel < tkri_pkg::NUM_LISTS) begin
          pos = 0;
          // ties keep the older entry ahead
          while (pos < DEPTH && !(it.score > list_scores[it.sel][pos]))
            pos++;
          if (pos < DEPTH) begin
            for (int j = DEPTH - 1; j > pos; j--) begin
              list_ids[it.sel][j]    = list_ids[it.sel][j-1];
              list_scores[it.sel][j] = list_scores[it.sel][j-1];
            end
            list_ids[it.sel][pos]    = it.id;
            list_scores[it.sel][pos] = it.score;
            r.placed = 1'b1;
            r.pslot  = tkri_pkg::PSLOT_W'(pos);
          end
        end
      end
      tkri_pkg::KIND_READ: begin
        if (it.sel < tkri_pkg::NUM_LISTS && it.slot < DEPTH) begin
          r.eid    = list_ids[it.sel][it.slot];
          r.escore = list_scores[it.sel][it.slot];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // random transaction, weighted so the lists fill up, tie and overflow
  function automatic item_t make_random_item();
    item_t it;
    int    pick;
    it.id   = $urandom;
    it.slot = ($urandom_range(0, 99) < 80)
              ? tkri_pkg::RSLOT_W'($urandom_range(0, DEPTH - 1))
              : tkri_pkg::RSLOT_W'($urandom_range(0, 15));
    it.sel  = ($urandom_range(0, 99) < 90)
              ? tkri_pkg::SEL_W'($urandom_range(0, tkri_pkg::NUM_LISTS - 1))
              : tkri_pkg::SEL_NONE;
    pick = $urandom_range(0, 99);
    if (pick < 5)
      it.score = '0;
    else if (pick < 55)
      it.score = tkri_pkg::SCORE_W'($urandom_range(1, 50));
    else if (pick < 85)
      it.score = tkri_pkg::SCORE_W'($urandom);
    else if (pick < 90)
      it.score = {tkri_pkg::SCORE_W{1'b1}};
    else
      it.score = {tkri_pkg::SCORE_W{1'b1}} - tkri_pkg::SCORE_W'($urandom_range(0, 20));
    pick = $urandom_range(0, 999);
    if (pick < 5)
      it.kind = tkri_pkg::KIND_CLEAR;
    else if (pick < 25)
      it.kind = KIND_UNUSED;
    else if (pick < 625)
      it.kind = tkri_pkg::KIND_INSERT;
    else
      it.kind = tkri_pkg::KIND_READ;
    return it;
  endfunction

  // drives one transaction, with random gaps ahead of it
  task automatic send_item(input item_t it, input bit fixed, input result_t answer);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_tvalid        <= 1'b1;
    s_tuser         <= it.kind;
    s_tdata         <= {3'b0, it.slot, it.score, it.id, it.sel};
    fixed_answer_on <= fixed;
    fixed_answer    <= answer;
    do @(posedge clk); while (!s_tready);
  endtask

  // receiver back-pressure
  always @(posedge clk)
    m_tready <= !rst && ($urandom_range(0, 99) >= recv_idle_pct);

  // result check first, then prediction of the transaction accepted at this edge
  always @(posedge clk) begin
    result_t got;
    result_t want;
    item_t   acc;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.placed = m_tdata[0];
        got.pslot  = m_tdata[4:1];
        got.eid    = m_tdata[36:5];
        got.escore = m_tdata[67:37];
        if (pending_results.size() == 0) begin
          $error("result with no transaction outstanding: %h", m_tdata);
          mismatch_seen = 1'b1;
        end else begin
          want = pending_results.pop_front();
          if (got.placed !== want.placed) begin
            $error("placed: expected %0d, got %0d", want.placed, got.placed);
            mismatch_seen = 1'b1;
          end
          if (got.pslot !== want.pslot) begin
            $error("placed_slot: expected %0d, got %0d", want.pslot, got.pslot);
            mismatch_seen = 1'b1;
          end
          if (got.eid !== want.eid) begin
            $error("entry_id: expected %h, got %h", want.eid, got.eid);
            mismatch_seen = 1'b1;
          end
          if (got.escore !== want.escore) begin
            $error("entry_score: expected %h, got %h", want.escore, got.escore);
            mismatch_seen = 1'b1;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        acc.kind  = s_tuser;
        acc.sel   = s_tdata[1:0];
        acc.id    = s_tdata[33:2];
        acc.score = s_tdata[64:34];
        acc.slot  = s_tdata[68:65];
        want = apply_to_lists(acc);
        pending_results.push_back(fixed_answer_on ? fixed_answer : want);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    for (int l = 0; l < tkri_pkg::NUM_LISTS; l++) begin
      for (int e = 0; e < DEPTH; e++) begin
        list_ids[l][e]    = '0;
        list_scores[l][e] = '0;
      end
    end

    // directed rows; fixed = 0 means the answer comes from the local lists
    directed_rows = '{
      // empty lists after reset
      '{'{tkri_pkg::KIND_READ, 2'd0, 32'h0, 31'h0, 4'd0}, 1'b1, ALL_ZERO},
      '{'{tkri_pkg::KIND_READ, 2'd2, 32'h0, 31'h0, 4'(DEPTH - 1)}, 1'b1, ALL_ZERO},
      // highest score and id into an empty list lands on top
      '{'{tkri_pkg::KIND_INSERT, 2'd0, 32'hFFFFFFFF, 31'h7FFFFFFF, 4'hF}, 1'b1, PLACED_TOP},
      // zero score is skipped
      '{'{tkri_pkg::KIND_INSERT, 2'd0, 32'h0, 31'h0, 4'd0}, 1'b1, ALL_ZERO},
      // no target list
      '{'{tkri_pkg::KIND_INSERT, tkri_pkg::SEL_NONE, 32'h12345678, 31'd1000, 4'd0},
        1'b1, ALL_ZERO},
      // tie at the top stays behind the older entry
      '{'{tkri_pkg::KIND_INSERT, 2'd0, 32'd1, 31'h7FFFFFFF, 4'd0}, 1'b0, ALL_ZERO},
      '{'{tkri_pkg::KIND_INSERT, 2'd0, 32'd2, 31'd1, 4'd0}, 1'b0, ALL_ZERO},
      '{'{tkri_pkg::KIND_INSERT, 2'd0, 32'd3, 31'd1, 4'd0}, 1'b0, ALL_ZERO},
      '{'{tkri_pkg::KIND_INSERT, 2'd0, 32'd4, 31'd2, 4'd0}, 1'b0, ALL_ZERO},
      '{'{tkri_pkg::KIND_INSERT, 2'd1, 32'hAAAAAAAA, 31'h55555555, 4'd0}, 1'b0, ALL_ZERO},
      '{'{tkri_pkg::KIND_INSERT, 2'd2, 32'h55555555, 31'h2AAAAAAA, 4'd0}, 1'b0, ALL_ZERO},
      '{'{tkri_pkg::KIND_READ, 2'd0, 32'h0, 31'h0, 4'd0}, 1'b0, ALL_ZERO},
      '{'{tkri_pkg::KIND_READ, 2'd0, 32'h0, 31'h0, 4'd1}, 1'b0, ALL_ZERO},
      '{'{tkri_pkg::KIND_READ, 2'd0, 32'h0, 31'h0, 4'd4}, 1'b0, ALL_ZERO},
      '{'{tkri_pkg::KIND_READ, 2'd0, 32'h0, 31'h0, 4'(DEPTH - 1)}, 1'b0, ALL_ZERO},
      // reads past the end of a list or of no list
      '{'{tkri_pkg::KIND_READ, 2'd0, 32'h0, 31'h0, 4'(DEPTH)}, 1'b1, ALL_ZERO},
      '{'{tkri_pkg::KIND_READ, 2'd1, 32'h0, 31'h0, 4'hF}, 1'b1, ALL_ZERO},
      '{'{tkri_pkg::KIND_READ, tkri_pkg::SEL_NONE, 32'h0, 31'h0, 4'd0}, 1'b1, ALL_ZERO},
      // unused kind with every input bit set
      '{'{KIND_UNUSED, tkri_pkg::SEL_NONE, 32'hFFFFFFFF, 31'h7FFFFFFF, 4'hF},
        1'b1, ALL_ZERO},
      // clear, then lists 0 and 1 read back empty
      '{'{tkri_pkg::KIND_CLEAR, 2'd0, 32'h0, 31'h0, 4'd0}, 1'b1, ALL_ZERO},
      '{'{tkri_pkg::KIND_READ, 2'd0, 32'h0, 31'h0, 4'd0}, 1'b1, ALL_ZERO},
      '{'{tkri_pkg::KIND_READ, 2'd1, 32'h0, 31'h0, 4'd0}, 1'b1, ALL_ZERO}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // sender idles a third of the time, receiver nearly two thirds
    send_idle_pct = 33;
    recv_idle_pct = 63;
    for (int i = 0; i < NUM_DIRECTED; i++)
      send_item(directed_rows[i].it, directed_rows[i].fixed, directed_rows[i].want);
    repeat (ITEMS_PER_PASS) send_item(make_random_item(), 1'b0, ALL_ZERO);

    // roles swapped
    send_idle_pct = 63;
    recv_idle_pct = 33;
    repeat (ITEMS_PER_PASS) send_item(make_random_item(), 1'b0, ALL_ZERO);

    // full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (ITEMS_PER_PASS) send_item(make_random_item(), 1'b0, ALL_ZERO);
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * DEPTH + 8) @(posedge clk);

    if (mismatch_seen || pending_results.size() != 0)
      $display("testbench NOT OK");
    else
      $display("testbench OK");
    $finish;
  end

endmodule

FILE: top_k_ranked_insert.f
rtl/tkri_pkg.sv
rtl/tkri_ram.sv
rtl/top_k_ranked_insert.sv
tb/testbench.sv
